// ----- rtl/json_chunk_char_classifier_assert.svh -----
// ----------------------------------------------------------------------------
// JSON chunk classifier assertion macros
// Concurrent checks clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef JSON_CHUNK_CHAR_CLASSIFIER_ASSERT_SVH
`define JSON_CHUNK_CHAR_CLASSIFIER_ASSERT_SVH

// same-cycle implication
`define JCCC_ASSERT_NOW(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define JCCC_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- rtl/jccc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jccc_pkg
// Shared constants and types for the JSON chunk character classifier.
// ----------------------------------------------------------------------------
package jccc_pkg;

    localparam int MAX_LANES   = 8;
    localparam int CHUNK_BYTES = 8;   // active lanes, 1..MAX_LANES
    localparam int COUNT_W     = 32;
    localparam int POP_W       = $clog2(MAX_LANES + 1);
    localparam int QDEPTH      = 2;

    localparam logic [7:0] CHR_LBRACE = 8'h7B;
    localparam logic [7:0] CHR_RBRACE = 8'h7D;
    localparam logic [7:0] CHR_LBRACK = 8'h5B;
    localparam logic [7:0] CHR_RBRACK = 8'h5D;
    localparam logic [7:0] CHR_COLON  = 8'h3A;
    localparam logic [7:0] CHR_COMMA  = 8'h2C;
    localparam logic [7:0] CHR_SPACE  = 8'h20;
    localparam logic [7:0] CHR_TAB    = 8'h09;
    localparam logic [7:0] CHR_LF     = 8'h0A;
    localparam logic [7:0] CHR_CR     = 8'h0D;
    localparam logic [7:0] CHR_QUOTE  = 8'h22;
    localparam logic [7:0] CHR_BSLASH = 8'h5C;

    typedef logic [MAX_LANES-1:0] lane_mask_t;
    typedef logic [COUNT_W-1:0]   count_t;

    typedef struct packed {
        logic structural;
        logic whitespace;
        logic quote;
        logic backslash;
    } lane_class_t;

    typedef struct packed {
        lane_mask_t structural_mask;
        lane_mask_t whitespace_mask;
        lane_mask_t quote_mask;
        lane_mask_t backslash_mask;
        lane_mask_t escaped_quote_mask;
        lane_mask_t real_quote_mask;
        count_t     structural_total;
        count_t     whitespace_total;
        logic       carry_odd;
    } result_t;

endpackage

// ----- rtl/jccc_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jccc_lane
// Classifies one text byte: structural, whitespace, quote, backslash.
// ----------------------------------------------------------------------------
module jccc_lane (
    input  logic [7:0]            text_byte,
    output jccc_pkg::lane_class_t lane_class
);
    import jccc_pkg::*;

    always_comb
    begin
        lane_class = '0;
        case (text_byte) inside
            CHR_LBRACE, CHR_RBRACE, CHR_LBRACK, CHR_RBRACK, CHR_COLON, CHR_COMMA:
                lane_class.structural = 1'b1;
            CHR_SPACE, CHR_TAB, CHR_LF, CHR_CR:
                lane_class.whitespace = 1'b1;
            CHR_QUOTE:
                lane_class.quote = 1'b1;
            CHR_BSLASH:
                lane_class.backslash = 1'b1;
            default:
                lane_class = '0;
        endcase
    end

endmodule

// ----- rtl/jccc_merge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jccc_merge
// Combines lane flags: backslash parity chain, escaped quotes, saturating
// totals, and a two-entry result queue toward the output.
// ----------------------------------------------------------------------------
`include "json_chunk_char_classifier_assert.svh"

module jccc_merge (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           in_valid,
    output logic                                           in_ready,
    input  logic                                           first_of_document,
    input  jccc_pkg::lane_class_t [jccc_pkg::MAX_LANES-1:0] lane_class,
    output logic                                           out_valid,
    input  logic                                           out_ready,
    output jccc_pkg::result_t                              result
);
    import jccc_pkg::*;

    logic       parity_reg,  parity_next;
    count_t     structural_count_reg, structural_count_next;
    count_t     whitespace_count_reg, whitespace_count_next;
    logic [1:0] fill_reg, fill_next;
    logic       wr_ptr_reg, rd_ptr_reg;
    result_t    queue_mem [QDEPTH];

    logic       in_fire, out_fire;
    logic       par;
    lane_mask_t smask, wmask, qmask, bmask, emask;
    logic [POP_W-1:0] s_inc, w_inc;
    count_t     base_s, base_w;
    logic [COUNT_W:0] s_sum, w_sum;
    result_t    res_next;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;
    assign in_ready  = (fill_reg != 2'(QDEPTH));
    assign out_valid = (fill_reg != 2'd0);
    assign result    = queue_mem[rd_ptr_reg];

    // parity of the open backslash run ripples lane to lane
    always_comb
    begin
        par   = first_of_document ? 1'b0 : parity_reg;
        smask = '0;
        wmask = '0;
        qmask = '0;
        bmask = '0;
        emask = '0;
        s_inc = '0;
        w_inc = '0;
        for (int i = 0; i < MAX_LANES; i++)
        begin
            if (i < CHUNK_BYTES)
            begin
                smask[i] = lane_class[i].structural;
                wmask[i] = lane_class[i].whitespace;
                qmask[i] = lane_class[i].quote;
                bmask[i] = lane_class[i].backslash;
                s_inc    = s_inc + POP_W'(lane_class[i].structural);
                w_inc    = w_inc + POP_W'(lane_class[i].whitespace);
                if (lane_class[i].backslash)
                begin
                    par = ~par;
                end
                else
                begin
                    emask[i] = lane_class[i].quote & par;
                    par      = 1'b0;
                end
            end
        end
        parity_next = par;
    end

    assign base_s = first_of_document ? '0 : structural_count_reg;
    assign base_w = first_of_document ? '0 : whitespace_count_reg;
    assign s_sum  = {1'b0, base_s} + (COUNT_W + 1)'(s_inc);
    assign w_sum  = {1'b0, base_w} + (COUNT_W + 1)'(w_inc);
    assign structural_count_next = s_sum[COUNT_W] ? '1 : s_sum[COUNT_W-1:0];
    assign whitespace_count_next = w_sum[COUNT_W] ? '1 : w_sum[COUNT_W-1:0];

    always_comb
    begin
        res_next.structural_mask    = smask;
        res_next.whitespace_mask    = wmask;
        res_next.quote_mask         = qmask;
        res_next.backslash_mask     = bmask;
        res_next.escaped_quote_mask = emask;
        res_next.real_quote_mask    = qmask & ~emask;
        res_next.structural_total   = structural_count_next;
        res_next.whitespace_total   = whitespace_count_next;
        res_next.carry_odd          = parity_next;
    end

    always_comb
    begin
        case ({in_fire, out_fire})
            2'b10:   fill_next = fill_reg + 2'd1;
            2'b01:   fill_next = fill_reg - 2'd1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parity_reg           <= 1'b0;
            structural_count_reg <= '0;
            whitespace_count_reg <= '0;
            fill_reg             <= 2'd0;
            wr_ptr_reg           <= 1'b0;
            rd_ptr_reg           <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (in_fire)
            begin
                parity_reg           <= parity_next;
                structural_count_reg <= structural_count_next;
                whitespace_count_reg <= whitespace_count_next;
                wr_ptr_reg           <= ~wr_ptr_reg;
            end
            if (out_fire)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            queue_mem[wr_ptr_reg] <= res_next;
        end
    end

    `JCCC_ASSERT_NOW(a_quote_split, out_valid,
        ((result.real_quote_mask & result.escaped_quote_mask) == '0) &&
        ((result.real_quote_mask | result.escaped_quote_mask) == result.quote_mask),
        "real and escaped quotes do not partition the quote mask")
    `JCCC_ASSERT_NEXT(a_parity_clear, in_fire && (bmask == '0), parity_reg == 1'b0,
        "backslash parity set after an item with no backslash")
    `JCCC_ASSERT_NEXT(a_totals_grow, in_fire && !first_of_document,
        (structural_count_reg >= $past(structural_count_reg)) &&
        (whitespace_count_reg >= $past(whitespace_count_reg)),
        "running total decreased within a document")
    `JCCC_ASSERT_NOW(a_full_stall, !in_ready, out_valid,
        "input stalled while result queue is empty")

endmodule

// ----- rtl/json_chunk_char_classifier.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_chunk_char_classifier
// Classifies an 8-byte JSON text chunk per lane and tracks escapes and totals.
// ----------------------------------------------------------------------------
// Each accepted result is registered in the result queue before it is output.
// Throughput: one item per cycle while the queue has room; backslash parity
//   and totals form combinationally: lane parity chain, 33-bit saturating add.
// A two-entry result queue keeps input open while one result waits.
// Reset (rst_n low, async) clears parity, both totals and the result queue.
module json_chunk_char_classifier (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] chunk_bytes,
    input  logic        first_of_document,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  structural_mask,
    output logic [7:0]  whitespace_mask,
    output logic [7:0]  quote_mask,
    output logic [7:0]  backslash_mask,
    output logic [7:0]  escaped_quote_mask,
    output logic [7:0]  real_quote_mask,
    output logic [31:0] structural_total,
    output logic [31:0] whitespace_total,
    output logic        carry_odd
);
    import jccc_pkg::*;

    lane_class_t [MAX_LANES-1:0] lane_class;
    result_t                     result;

    for (genvar i = 0; i < MAX_LANES; i++)
    begin : g_lane
        jccc_lane u_lane (
            .text_byte  (chunk_bytes[8*i +: 8]),
            .lane_class (lane_class[i])
        );
    end

    jccc_merge u_merge (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .first_of_document (first_of_document),
        .lane_class        (lane_class),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .result            (result)
    );

    assign structural_mask    = result.structural_mask;
    assign whitespace_mask    = result.whitespace_mask;
    assign quote_mask         = result.quote_mask;
    assign backslash_mask     = result.backslash_mask;
    assign escaped_quote_mask = result.escaped_quote_mask;
    assign real_quote_mask    = result.real_quote_mask;
    assign structural_total   = result.structural_total;
    assign whitespace_total   = result.whitespace_total;
    assign carry_odd          = result.carry_odd;

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for json_chunk_char_classifier. A directed set of chunks
// covers every byte class, escapes inside and across chunks, and document
// restarts. It is followed by random JSON-like documents and raw noise. Each
// item is predicted in the bench and compared field by field with the result.
// ----------------------------------------------------------------------------
module tb;
    import jccc_pkg::*;

    localparam int CLK_HALF       = 2;
    localparam int CYCLE_LIMIT    = 100000;
    localparam int TOTAL_ITEMS    = 850;
    localparam int PHASE_A_END    = 300;
    localparam int PHASE_B_END    = 600;
    localparam int HOLDOFF_AT     = 650;
    localparam int HOLDOFF_CYCLES = 64;
    localparam int DRAIN_CYCLES   = 16;

    localparam logic [47:0] STRUCT_SET = {CHR_LBRACE, CHR_RBRACE, CHR_LBRACK,
                                          CHR_RBRACK, CHR_COLON, CHR_COMMA};
    localparam logic [31:0] WS_SET     = {CHR_SPACE, CHR_TAB, CHR_LF, CHR_CR};

    typedef struct packed {
        logic [63:0] text;
        logic        first_doc;
    } chunk_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [63:0] chunk_bytes = '0;
    logic        first_of_document = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    lane_mask_t  structural_mask;
    lane_mask_t  whitespace_mask;
    lane_mask_t  quote_mask;
    lane_mask_t  backslash_mask;
    lane_mask_t  escaped_quote_mask;
    lane_mask_t  real_quote_mask;
    count_t      structural_total;
    count_t      whitespace_total;
    logic        carry_odd;

    chunk_item_t chunks_to_send[$];
    result_t     expected_results[$];

    // predicted block state
    logic   pred_parity = 1'b0;
    count_t pred_structural = '0;
    count_t pred_whitespace = '0;

    logic in_fire = 1'b0;
    int   holdoff_left = 0;
    logic holdoff_done = 1'b0;
    int   items_in = 0;
    int   results_out = 0;
    int   error_count = 0;
    int   stall_cycles = 0;
    int   escaped_seen = 0;
    int   documents = 0;
    int   cycle_count = 0;

    json_chunk_char_classifier DUT (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .chunk_bytes        (chunk_bytes),
        .first_of_document  (first_of_document),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .structural_mask    (structural_mask),
        .whitespace_mask    (whitespace_mask),
        .quote_mask         (quote_mask),
        .backslash_mask     (backslash_mask),
        .escaped_quote_mask (escaped_quote_mask),
        .real_quote_mask    (real_quote_mask),
        .structural_total   (structural_total),
        .whitespace_total   (whitespace_total),
        .carry_odd          (carry_odd)
    );

    initial forever #CLK_HALF clk = ~clk;

    // Classifies one chunk and advances the predicted parity and totals.
    function automatic result_t classify_chunk(input logic [63:0] text,
                                               input logic first_doc);
        result_t     r;
        logic [7:0]  ch;
        logic        odd_run;
        logic [32:0] sum;
        int          lanes;
        int          n_struct;
        int          n_ws;
        int          i;
        lanes = (CHUNK_BYTES > MAX_LANES) ? MAX_LANES : CHUNK_BYTES;
        r = '0;
        n_struct = 0;
        n_ws = 0;
        if (first_doc)
        begin
            pred_parity = 1'b0;
            pred_structural = '0;
            pred_whitespace = '0;
        end
        odd_run = pred_parity;
        for (i = 0; i < lanes; i++)
        begin
            ch = text[8*i +: 8];
            if (ch == CHR_LBRACE || ch == CHR_RBRACE || ch == CHR_LBRACK ||
                ch == CHR_RBRACK || ch == CHR_COLON || ch == CHR_COMMA)
            begin
                r.structural_mask[i] = 1'b1;
                n_struct++;
            end
            if (ch == CHR_SPACE || ch == CHR_TAB || ch == CHR_LF || ch == CHR_CR)
            begin
                r.whitespace_mask[i] = 1'b1;
                n_ws++;
            end
            if (ch == CHR_BSLASH)
            begin
                r.backslash_mask[i] = 1'b1;
                odd_run = ~odd_run;
            end
            else
            begin
                // any other byte ends the run, a quote included
                if (ch == CHR_QUOTE)
                begin
                    r.quote_mask[i] = 1'b1;
                    r.escaped_quote_mask[i] = odd_run;
                end
                odd_run = 1'b0;
            end
        end
        r.real_quote_mask = r.quote_mask & ~r.escaped_quote_mask;
        sum = {1'b0, pred_structural} + 33'(n_struct);
        pred_structural = sum[32] ? '1 : sum[31:0];
        sum = {1'b0, pred_whitespace} + 33'(n_ws);
        pred_whitespace = sum[32] ? '1 : sum[31:0];
        pred_parity = odd_run;
        r.structural_total = pred_structural;
        r.whitespace_total = pred_whitespace;
        r.carry_odd = odd_run;
        return r;
    endfunction

    // Random byte weighted toward the characters that matter in JSON text.
    function automatic logic [7:0] json_byte();
        int pick;
        int k;
        pick = $urandom_range(99);
        if (pick < 15)
        begin
            k = $urandom_range(5);
            return STRUCT_SET[8*k +: 8];
        end
        if (pick < 28)
        begin
            k = $urandom_range(3);
            return WS_SET[8*k +: 8];
        end
        if (pick < 38)
            return CHR_QUOTE;
        if (pick < 55)
            return CHR_BSLASH;
        if (pick < 95)
            return 8'($urandom_range(8'h7E, 8'h21));
        return 8'($urandom_range(255));
    endfunction

    // Lane i takes character i of s; short strings are padded with 'a'.
    function automatic logic [63:0] pack_text(input string s);
        logic [63:0] text;
        int          i;
        text = {8{8'h61}};
        for (i = 0; i < 8 && i < s.len(); i++)
            text[8*i +: 8] = s[i];
        return text;
    endfunction

    function automatic void add_chunk(input logic [63:0] text, input logic first_doc);
        chunks_to_send.push_back({text, first_doc});
        if (first_doc)
            documents++;
    endfunction

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_error($sformatf("result %0d %s: got %h, expected %h",
                                   results_out, name, got, want));
    endtask

    // Sender: holds the item until taken, then loads the next or idles.
    always @(negedge clk)
    begin : send_proc
        chunk_item_t next_item;
        int          idle_pct;
        if (rst_n && (!in_valid || in_fire))
        begin
            idle_pct = (items_in < PHASE_A_END) ? 6 : (items_in < PHASE_B_END) ? 48 : 0;
            if (chunks_to_send.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                next_item = chunks_to_send.pop_front();
                chunk_bytes <= next_item.text;
                first_of_document <= next_item.first_doc;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // One long output stall while the sender keeps pushing, to fill the block.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!holdoff_done && items_in >= HOLDOFF_AT)
            begin
                holdoff_left <= HOLDOFF_CYCLES;
                holdoff_done <= 1'b1;
            end
            else if (holdoff_left != 0)
                holdoff_left <= holdoff_left - 1;
        end
    end

    always @(negedge clk)
    begin : recv_proc
        int stall_pct;
        if (rst_n)
        begin
            stall_pct = (items_in < PHASE_A_END) ? 48 : (items_in < PHASE_B_END) ? 6 : 0;
            out_ready <= (holdoff_left == 0) && ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin : monitor_proc
        result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                    report_error($sformatf("result %0d arrived with none outstanding",
                                           results_out));
                else
                begin
                    want = expected_results.pop_front();
                    check_field("structural_mask", 32'(structural_mask),
                                32'(want.structural_mask));
                    check_field("whitespace_mask", 32'(whitespace_mask),
                                32'(want.whitespace_mask));
                    check_field("quote_mask", 32'(quote_mask), 32'(want.quote_mask));
                    check_field("backslash_mask", 32'(backslash_mask),
                                32'(want.backslash_mask));
                    check_field("escaped_quote_mask", 32'(escaped_quote_mask),
                                32'(want.escaped_quote_mask));
                    check_field("real_quote_mask", 32'(real_quote_mask),
                                32'(want.real_quote_mask));
                    check_field("structural_total", structural_total,
                                want.structural_total);
                    check_field("whitespace_total", whitespace_total,
                                want.whitespace_total);
                    check_field("carry_odd", 32'(carry_odd), 32'(want.carry_odd));
                end
                results_out++;
            end
            in_fire = in_valid && in_ready;
            if (in_fire)
            begin
                want = classify_chunk(chunk_bytes, first_of_document);
                expected_results.push_back(want);
                escaped_seen += $countones(want.escaped_quote_mask);
                items_in++;
            end
            if (in_valid && !in_ready)
                stall_cycles++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles: %0d of %0d results seen", cycle_count,
                     results_out, items_in);
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        logic [63:0] text;
        int          kind;
        int          doc_len;
        int          n_total;
        int          c;
        int          b;

        // directed: byte classes, escapes within and across chunks, restarts
        add_chunk(64'h0, 1'b1);
        add_chunk('1, 1'b0);
        add_chunk(pack_text("{}[]:,{]"), 1'b0);
        add_chunk({CHR_SPACE, CHR_TAB, CHR_LF, CHR_CR,
                   CHR_SPACE, CHR_TAB, CHR_LF, CHR_CR}, 1'b0);
        add_chunk(pack_text("\"a\"\\\"b\\\\"), 1'b0);
        add_chunk(pack_text("\"\\\\\\\"x\\\""), 1'b0);
        add_chunk(pack_text("abcdefg\\"), 1'b0);         // odd run into next chunk
        add_chunk(pack_text("\"abcdefg"), 1'b0);
        add_chunk(pack_text("abcdef\\\\"), 1'b0);        // even run into next chunk
        add_chunk(pack_text("\",:{ }[]"), 1'b0);
        add_chunk(pack_text("abcdefg\\"), 1'b0);
        add_chunk(pack_text("\\\\\\\\\\\\\\\\"), 1'b0);  // run spans three chunks
        add_chunk(pack_text("\\\\\\\\\\\\\\\\"), 1'b0);
        add_chunk(pack_text("\"zzzzzzz"), 1'b0);
        add_chunk(pack_text("abcdefg\\"), 1'b0);
        add_chunk(pack_text("\"{}\"xx\\\""), 1'b1);      // restart drops the odd run
        add_chunk(pack_text("\\a\"mmm\\\""), 1'b0);
        add_chunk(pack_text("\"\"\"\"\"\"\"\""), 1'b0);
        add_chunk(64'h7E7C7A5E5A3B392B, 1'b0);           // neighbors of class bytes
        add_chunk(64'h2D2321201F0E0C0B, 1'b0);
        add_chunk(64'h08015D5C5B7D7B3A, 1'b0);
        add_chunk(64'hA2DCFBFDDBBAAC89, 1'b0);           // class bytes with bit 7 set
        add_chunk(pack_text("\\\\\\\\\\\\\\\""), 1'b0);

        // random: mostly JSON-like documents, some raw noise
        while (chunks_to_send.size() < TOTAL_ITEMS)
        begin
            kind = $urandom_range(99);
            if (kind < 10)
                add_chunk({$urandom, $urandom}, 1'($urandom_range(1)));
            else
            begin
                doc_len = ($urandom_range(9) == 0) ? $urandom_range(40, 12)
                                                   : $urandom_range(8, 1);
                for (c = 0; c < doc_len; c++)
                begin
                    for (b = 0; b < 8; b++)
                        text[8*b +: 8] = json_byte();
                    add_chunk(text, c == 0);
                end
            end
        end
        n_total = chunks_to_send.size();

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (items_in < n_total)
            @(negedge clk);
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d chunks in %0d documents, %0d results checked, %0d escaped quotes",
                 items_in, documents, results_out, escaped_seen);
        $display("%0d input stall cycles, %0d mismatches", stall_cycles, error_count);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/jccc_pkg.sv
rtl/jccc_lane.sv
rtl/jccc_merge.sv
rtl/json_chunk_char_classifier.sv
bench/tb.sv
